@@ design/mvw_pkg.sv @@
// Shared types and constants for the modular vector-by-matrix block.
// Used by the channel interfaces, the cell row, the sequencer and the top level.
package mvw_pkg;

  localparam int OP_BITS       = 2;
  localparam int GEN_BITS      = 4;
  localparam int IDX_BITS      = 4;
  localparam int ENTRY_BITS    = 8;
  localparam int VALUE_BITS    = 8;
  localparam int MOD_BITS      = 8;
  localparam int DIM_BITS      = 5;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 8;

  localparam int MODULUS_MIN   = 2;
  localparam int MODULUS_RESET = 2;
  localparam int DIM_RESET     = 16;

  typedef enum logic [OP_BITS-1:0] {
    OP_LOAD_MAT = 2'd0,
    OP_LOAD_VEC = 2'd1,
    OP_APPLY    = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MODULUS    = 2'd0,
    CFG_ACTIVE_DIM = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_MUL,
    ST_RAW,
    ST_RED,
    ST_COMMIT,
    ST_EMIT
  } state_t;

  // Strobes broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic clear_acc;
    logic mul;
    logic rotate;
    logic load_raw;
    logic red;
    logic commit;
    logic shift;
  } cell_ctl_t;

endpackage

@@ design/mvw_in_if.sv @@
// Input channel: one load or apply item with valid/ready.
// Field widths come from mvw_pkg.
interface mvw_in_if;
  logic                            valid;
  logic                            ready;
  logic [mvw_pkg::OP_BITS-1:0]     operation;
  logic [mvw_pkg::GEN_BITS-1:0]    generator;
  logic [mvw_pkg::IDX_BITS-1:0]    row;
  logic [mvw_pkg::IDX_BITS-1:0]    column;
  logic [mvw_pkg::ENTRY_BITS-1:0]  entry;

  modport source (output valid, operation, generator, row, column, entry, input ready);
  modport sink   (input valid, operation, generator, row, column, entry, output ready);
endinterface

@@ design/mvw_out_if.sv @@
// Result channel: one vector element per item with a last mark.
// Field widths come from mvw_pkg.
interface mvw_out_if;
  logic                            valid;
  logic                            ready;
  logic [mvw_pkg::IDX_BITS-1:0]    element_index;
  logic [mvw_pkg::VALUE_BITS-1:0]  element_value;
  logic                            last;

  modport source (output valid, element_index, element_value, last, input ready);
  modport sink   (input valid, element_index, element_value, last, output ready);
endinterface

@@ design/mvw_cfg_if.sv @@
// Configuration write channel: register index and data with valid/ready.
// Field widths come from mvw_pkg.
interface mvw_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mvw_pkg::CFG_IDX_BITS-1:0]   index;
  logic [mvw_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/mvw_cell.sv @@
// One cell of the row: a vector element, a column accumulator and a
// bit-serial remainder unit. Depends on mvw_pkg for the control struct.
module mvw_cell #(
  parameter int ELEM_BITS = 8,
  parameter int XW        = 17
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mvw_pkg::cell_ctl_t            ctl,
  input  logic                          active,
  input  logic                          vec_we,
  input  logic [ELEM_BITS-1:0]          vec_wdata,
  input  logic [ELEM_BITS-1:0]          vec_nbr,
  input  logic [ELEM_BITS-1:0]          coef,
  input  logic [ELEM_BITS-1:0]          ent,
  input  logic [mvw_pkg::MOD_BITS-1:0]  acc_nbr,
  input  logic [mvw_pkg::MOD_BITS-1:0]  modulus,
  output logic [ELEM_BITS-1:0]          vec_q,
  output logic [mvw_pkg::MOD_BITS-1:0]  acc_q
);

  localparam int PW = 2 * ELEM_BITS;
  localparam int MW = mvw_pkg::MOD_BITS;

  logic [ELEM_BITS-1:0] vec_r;
  logic [MW-1:0]        acc_r;
  logic [XW-1:0]        x_r;
  logic [PW-1:0]        prod;
  logic [MW:0]          rem_t;
  logic [MW:0]          rem_s;
  logic [MW-1:0]        rem_nxt;
  logic [ELEM_BITS-1:0] acc_trunc;

  // Force a clean zero when the vector element is zero.
  assign prod = (coef == '0) ? '0 : PW'(coef) * PW'(ent);

  // Restoring remainder: shift in one bit of x, subtract the modulus if it fits.
  assign rem_t   = {acc_r, x_r[XW-1]};
  assign rem_s   = rem_t - {1'b0, modulus};
  assign rem_nxt = (rem_t >= {1'b0, modulus}) ? rem_s[MW-1:0] : rem_t[MW-1:0];

  assign acc_trunc = ELEM_BITS'(acc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_r <= '0;
    end else if (vec_we) begin
      vec_r <= vec_wdata;
    end else if (ctl.rotate && active) begin
      vec_r <= vec_nbr;
    end else if (ctl.commit && active) begin
      vec_r <= acc_trunc;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear_acc) begin
      acc_r <= '0;
    end else if (ctl.mul) begin
      x_r   <= XW'(acc_r) + XW'(prod);
      acc_r <= '0;
    end else if (ctl.load_raw) begin
      x_r   <= XW'(vec_r);
      acc_r <= '0;
    end else if (ctl.red) begin
      acc_r <= rem_nxt;
      x_r   <= x_r << 1;
    end else if (ctl.commit) begin
      acc_r <= MW'(acc_trunc);
    end else if (ctl.shift) begin
      acc_r <= acc_nbr;
    end
  end

  assign vec_q = vec_r;
  assign acc_q = acc_r;

endmodule

@@ design/mvw_ctrl.sv @@
// Sequencer: walks matrix rows and remainder bits for an apply, then streams
// the result vector through the output register. Depends on mvw_pkg.
module mvw_ctrl #(
  parameter int CW = 4,
  parameter int XW = 17
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [mvw_pkg::OP_BITS-1:0]     in_op,
  input  logic                            in_gen_ok,
  output logic                            in_ready,
  input  logic [CW-1:0]                   dim_last,
  input  logic [mvw_pkg::MOD_BITS-1:0]    acc_head,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [mvw_pkg::IDX_BITS-1:0]    out_idx,
  output logic [mvw_pkg::MOD_BITS-1:0]    out_val,
  output logic                            out_last,
  output logic [CW-1:0]                   row_cnt,
  output logic                            rd_en,
  output mvw_pkg::cell_ctl_t              ctl
);

  localparam int BW = $clog2(XW);
  localparam int IW = mvw_pkg::IDX_BITS;
  localparam int MW = mvw_pkg::MOD_BITS;
  localparam logic [BW-1:0] BIT_LAST = BW'(XW - 1);

  mvw_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   row_r, row_nxt;
  logic [BW-1:0]   bit_r, bit_nxt;
  logic            gen_ok_r, gen_ok_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [IW-1:0]   out_idx_r, out_idx_nxt;
  logic [MW-1:0]   out_val_r, out_val_nxt;
  logic            out_last_r, out_last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mvw_pkg::ST_IDLE;
      row_r       <= '0;
      bit_r       <= '0;
      gen_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      bit_r       <= bit_nxt;
      gen_ok_r    <= gen_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_idx_r  <= out_idx_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    bit_nxt       = bit_r;
    gen_ok_nxt    = gen_ok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    ctl           = '0;
    rd_en         = 1'b0;

    case (state_r)
      mvw_pkg::ST_IDLE: begin
        if (in_valid && (in_op == mvw_pkg::OP_APPLY)) begin
          gen_ok_nxt    = in_gen_ok;
          row_nxt       = '0;
          ctl.clear_acc = 1'b1;
          state_nxt     = in_gen_ok ? mvw_pkg::ST_RD : mvw_pkg::ST_RAW;
        end
      end
      mvw_pkg::ST_RD: begin
        rd_en     = 1'b1;
        state_nxt = mvw_pkg::ST_MUL;
      end
      mvw_pkg::ST_MUL: begin
        ctl.mul    = 1'b1;
        ctl.rotate = 1'b1;
        bit_nxt    = '0;
        state_nxt  = mvw_pkg::ST_RED;
      end
      mvw_pkg::ST_RAW: begin
        // Unknown generator: reduce the held vector for output only.
        ctl.load_raw = 1'b1;
        bit_nxt      = '0;
        state_nxt    = mvw_pkg::ST_RED;
      end
      mvw_pkg::ST_RED: begin
        ctl.red = 1'b1;
        bit_nxt = bit_r + BW'(1);
        if (bit_r == BIT_LAST) begin
          if (!gen_ok_r) begin
            row_nxt   = '0;
            state_nxt = mvw_pkg::ST_EMIT;
          end else if (row_r == dim_last) begin
            state_nxt = mvw_pkg::ST_COMMIT;
          end else begin
            row_nxt   = row_r + CW'(1);
            state_nxt = mvw_pkg::ST_RD;
          end
        end
      end
      mvw_pkg::ST_COMMIT: begin
        ctl.commit = 1'b1;
        row_nxt    = '0;
        state_nxt  = mvw_pkg::ST_EMIT;
      end
      mvw_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          ctl.shift     = 1'b1;
          out_valid_nxt = 1'b1;
          out_idx_nxt   = IW'(row_r);
          out_val_nxt   = acc_head;
          out_last_nxt  = (row_r == dim_last);
          if (row_r == dim_last) begin
            state_nxt = mvw_pkg::ST_IDLE;
          end else begin
            row_nxt = row_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = mvw_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == mvw_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_idx   = out_idx_r;
  assign out_val   = out_val_r;
  assign out_last  = out_last_r;
  assign row_cnt   = row_r;

`ifndef ASSERT_OFF
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && (state_r == mvw_pkg::ST_IDLE))
    else $error("output or sequencer not cleared by reset");

  a_no_accept_mid_vector: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(out_valid_r && !out_last_r))
    else $error("input taken while a result vector is still streaming");

  a_vector_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !out_last_r |=> out_valid_r)
    else $error("gap inside a result vector");

  a_bit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mvw_pkg::ST_RED) |-> (bit_r <= BIT_LAST))
    else $error("remainder bit counter past its end");
`endif

endmodule

@@ design/modp_vector_matrix_word_action_core.sv @@
// Modular vector-by-matrix block, top level: matrix store, cell row, sequencer.
// Depends on mvw_pkg, the channel interfaces, mvw_cell and mvw_ctrl.
//
// Usage:
//   in_ch carries items: load matrix entry (generator, row, column, entry), load
//   vector element (row, entry) or apply generator (generator). Loads are
//   accepted back to back while the block is idle; they give no result.
//   An apply multiplies the held row vector by the named matrix modulo the
//   modulus and streams the dim elements of the new vector on out_ch, index
//   0 first, last set on the final one. One result per cycle once streaming,
//   while the receiver is ready. For each row of the product one matrix row is
//   read from the store and the per-cell bit-serial remainder runs over XW =
//   max(2 * ELEM_BITS, 8) + 1 bits (17 by default), one bit a cycle. An
//   unknown generator emits the held vector reduced modulo the modulus and
//   leaves it unchanged.
//   cfg_ch writes modulus (index 0) and active_dim (index 1), always ready;
//   write only while the block is idle.
//   Reset: vector cleared, modulus 2, active_dim 16; the matrix store is not
//   cleared and must be written before use.
//   A stalled receiver holds the output register; streaming pauses with it
//   and no input is taken until the last element has been loaded.
module modp_vector_matrix_word_action_core #(
  parameter int MAX_DIM        = 16,
  parameter int NUM_GENERATORS = 16,
  parameter int ELEM_BITS      = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  mvw_in_if.sink     in_ch,
  mvw_out_if.source  out_ch,
  mvw_cfg_if.sink    cfg_ch
);

  localparam int ROWS = NUM_GENERATORS * MAX_DIM;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int MW   = mvw_pkg::MOD_BITS;
  localparam int DW   = mvw_pkg::DIM_BITS;
  localparam int GW   = mvw_pkg::GEN_BITS;
  localparam int XW   = ((2 * ELEM_BITS > MW) ? 2 * ELEM_BITS : MW) + 1;

  // Configuration registers
  logic [MW-1:0] modulus_r;
  logic [DW-1:0] dim_r;
  logic [MW-1:0] m_eff;
  logic [CW-1:0] dim_last;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MW'(mvw_pkg::MODULUS_RESET);
      dim_r     <= DW'(mvw_pkg::DIM_RESET);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        mvw_pkg::CFG_MODULUS:    modulus_r <= MW'(cfg_ch.data);
        mvw_pkg::CFG_ACTIVE_DIM: dim_r     <= DW'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  assign m_eff = (modulus_r < MW'(mvw_pkg::MODULUS_MIN)) ? MW'(mvw_pkg::MODULUS_MIN)
                                                         : modulus_r;

  // Clamp the dimension into 1..MAX_DIM, kept as the index of the last element.
  always_comb begin
    if (dim_r == '0) begin
      dim_last = '0;
    end else if (32'(dim_r) > MAX_DIM) begin
      dim_last = CW'(MAX_DIM - 1);
    end else begin
      dim_last = CW'(32'(dim_r) - 1);
    end
  end

  // Input decode
  logic          in_fire;
  logic          gen_ok;
  logic          row_ok;
  logic          col_ok;
  logic          mat_we;
  logic          vec_load;
  logic [AW-1:0] waddr;
  logic [CW-1:0] wcol;
  logic [GW-1:0] gen_r;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign gen_ok   = (32'(in_ch.generator) < NUM_GENERATORS);
  assign row_ok   = (32'(in_ch.row) < MAX_DIM);
  assign col_ok   = (32'(in_ch.column) < MAX_DIM);
  assign mat_we   = in_fire && (in_ch.operation == mvw_pkg::OP_LOAD_MAT)
                    && gen_ok && row_ok && col_ok;
  assign vec_load = in_fire && (in_ch.operation == mvw_pkg::OP_LOAD_VEC);
  assign waddr    = AW'(32'(in_ch.generator) * MAX_DIM + 32'(in_ch.row));
  assign wcol     = CW'(in_ch.column);

  always_ff @(posedge clk) begin
    if (in_fire && (in_ch.operation == mvw_pkg::OP_APPLY)) begin
      gen_r <= in_ch.generator;
    end
  end

  // Matrix store: one row of MAX_DIM entries per address, per-entry write.
  logic [MAX_DIM-1:0][ELEM_BITS-1:0] mat_mem [ROWS];
  logic [MAX_DIM-1:0][ELEM_BITS-1:0] rdata_r;
  logic [AW-1:0]                     raddr;
  logic [CW-1:0]                     row_cnt;
  logic                              rd_en;

  assign raddr = AW'(32'(gen_r) * MAX_DIM + 32'(row_cnt));

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[waddr][wcol] <= ELEM_BITS'(in_ch.entry);
    end
    if (rd_en) begin
      rdata_r <= mat_mem[raddr];
    end
  end

  // Cell row
  mvw_pkg::cell_ctl_t   cell_ctl;
  logic [ELEM_BITS-1:0] vec_q [MAX_DIM];
  logic [MW-1:0]        acc_q [MAX_DIM];

  for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
    localparam logic [CW-1:0] KI = CW'(k);
    logic [ELEM_BITS-1:0] nbr_vec;
    logic [MW-1:0]        nbr_acc;

    // Rotate the vector within the active part; shift results toward cell 0.
    if (k == MAX_DIM - 1) begin : g_tail
      assign nbr_vec = vec_q[0];
      assign nbr_acc = '0;
    end else begin : g_body
      assign nbr_vec = (KI == dim_last) ? vec_q[0] : vec_q[k+1];
      assign nbr_acc = acc_q[k+1];
    end

    mvw_cell #(
      .ELEM_BITS (ELEM_BITS),
      .XW        (XW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .active    (KI <= dim_last),
      .vec_we    (vec_load && (32'(in_ch.row) == k)),
      .vec_wdata (ELEM_BITS'(in_ch.entry)),
      .vec_nbr   (nbr_vec),
      .coef      (vec_q[0]),
      .ent       (rdata_r[k]),
      .acc_nbr   (nbr_acc),
      .modulus   (m_eff),
      .vec_q     (vec_q[k]),
      .acc_q     (acc_q[k])
    );
  end

  mvw_ctrl #(
    .CW (CW),
    .XW (XW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.operation),
    .in_gen_ok (gen_ok),
    .in_ready  (in_ch.ready),
    .dim_last  (dim_last),
    .acc_head  (acc_q[0]),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_idx   (out_ch.element_index),
    .out_val   (out_ch.element_value),
    .out_last  (out_ch.last),
    .row_cnt   (row_cnt),
    .rd_en     (rd_en),
    .ctl       (cell_ctl)
  );

endmodule

@@ test/tb_modp_vector_matrix_word_action_core.sv @@
// Testbench for modp_vector_matrix_word_action_core: checks every emitted vector element
// against a predictor of the vector-by-matrix action mod the configured modulus.
// Depends on mvw_pkg and the mvw_in_if, mvw_out_if and mvw_cfg_if interfaces.
module tb_modp_vector_matrix_word_action_core;
  import mvw_pkg::*;

  localparam int DIM_MAX        = 16;
  localparam int GEN_COUNT      = 16;
  localparam int SETTLE_CYCLES  = 40;
  localparam int LONG_HOLD      = 600;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_PRINTS     = 50;
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_BITS-1:0]    op;
    logic [GEN_BITS-1:0]   gen;
    logic [IDX_BITS-1:0]   row;
    logic [IDX_BITS-1:0]   col;
    logic [ENTRY_BITS-1:0] entry;
  } action_item_t;

  typedef struct {
    logic [IDX_BITS-1:0]   idx;
    logic [VALUE_BITS-1:0] value;
    logic                  last;
  } element_t;

  logic clk;
  logic rst_n;

  mvw_in_if  in_ch();
  mvw_out_if out_ch();
  mvw_cfg_if cfg_ch();

  modp_vector_matrix_word_action_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state
  logic [ENTRY_BITS-1:0] pred_mat [GEN_COUNT][DIM_MAX][DIM_MAX];
  bit                    mat_loaded [GEN_COUNT][DIM_MAX][DIM_MAX];
  logic [ENTRY_BITS-1:0] pred_vec [DIM_MAX];
  logic [MOD_BITS-1:0]   pred_modulus;
  logic [DIM_BITS-1:0]   pred_dim;

  element_t pending_elements[$];
  element_t head_elem;

  int  error_count;
  int  print_count;
  int  items_sent;
  int  burst_left;
  int  quiet_cycles;
  bit  long_hold_req;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (print_count < MAX_PRINTS) begin
      print_count++;
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  function automatic int unsigned eff_modulus();
    return (pred_modulus < MODULUS_MIN) ? MODULUS_MIN : pred_modulus;
  endfunction

  function automatic int unsigned eff_dim();
    if (pred_dim < 1) return 1;
    if (pred_dim > DIM_MAX) return DIM_MAX;
    return pred_dim;
  endfunction

  function automatic void reset_predictor();
    pred_modulus = MODULUS_RESET;
    pred_dim     = DIM_RESET;
    foreach (pred_vec[i]) pred_vec[i] = '0;
    foreach (mat_loaded[g, r, c]) mat_loaded[g][r][c] = 1'b0;
  endfunction

  function automatic void predict_vector_action(input action_item_t it);
    int unsigned m;
    int unsigned dim;
    int unsigned acc;
    logic [ENTRY_BITS-1:0] fresh [DIM_MAX];
    bit nonzero;
    element_t el;
    m   = eff_modulus();
    dim = eff_dim();
    case (it.op)
      OP_LOAD_MAT: begin
        pred_mat[it.gen][it.row][it.col]   = it.entry;
        mat_loaded[it.gen][it.row][it.col] = 1'b1;
      end
      OP_LOAD_VEC: begin
        pred_vec[it.row] = it.entry;
      end
      OP_APPLY: begin
        nonzero = 1'b0;
        for (int i = 0; i < dim; i++)
          if (pred_vec[i] != 0) nonzero = 1'b1;
        // A zero vector stays zero: leave it untouched
        if (nonzero) begin
          for (int j = 0; j < dim; j++) begin
            acc = 0;
            for (int i = 0; i < dim; i++)
              acc = (acc + int'(pred_vec[i]) * int'(pred_mat[it.gen][i][j])) % m;
            fresh[j] = acc[ENTRY_BITS-1:0];
          end
          for (int j = 0; j < dim; j++) pred_vec[j] = fresh[j];
        end
        for (int j = 0; j < dim; j++) begin
          el.idx   = j[IDX_BITS-1:0];
          el.value = VALUE_BITS'(int'(pred_vec[j]) % m);
          el.last  = (j == dim - 1);
          pending_elements.push_back(el);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic bit gen_loaded(input int g);
    int dim;
    dim = eff_dim();
    for (int i = 0; i < dim; i++)
      for (int j = 0; j < dim; j++)
        if (!mat_loaded[g][i][j]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [GEN_BITS-1:0] pick_loaded_gen();
    int g;
    for (int tries = 0; tries < 16; tries++) begin
      g = $urandom_range(0, GEN_COUNT - 1);
      if (gen_loaded(g)) return g[GEN_BITS-1:0];
    end
    for (g = 0; g < GEN_COUNT; g++)
      if (gen_loaded(g)) return g[GEN_BITS-1:0];
    return '0;
  endfunction

  function automatic logic [ENTRY_BITS-1:0] random_entry();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, eff_modulus() - 1);
  endfunction

  // Valid stays high after an accept; the next send or a drain decides its level.
  task automatic send_item(input logic [OP_BITS-1:0] op, input logic [GEN_BITS-1:0] gen,
                           input logic [IDX_BITS-1:0] row, input logic [IDX_BITS-1:0] col,
                           input logic [ENTRY_BITS-1:0] entry);
    action_item_t it;
    it.op = op; it.gen = gen; it.row = row; it.col = col; it.entry = entry;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= it.op;
    in_ch.generator <= it.gen;
    in_ch.row       <= it.row;
    in_ch.column    <= it.col;
    in_ch.entry     <= it.entry;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    if (it.op != OP_UNUSED) items_sent++;
    predict_vector_action(it);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_elements.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_MODULUS) pred_modulus = data;
    else pred_dim = data[DIM_BITS-1:0];
  endtask

  task automatic set_config(input logic [CFG_DATA_BITS-1:0] modulus,
                            input logic [CFG_DATA_BITS-1:0] dim);
    drain_results();
    write_reg(CFG_MODULUS, modulus);
    write_reg(CFG_ACTIVE_DIM, dim);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic fill_generator(input logic [GEN_BITS-1:0] g);
    int dim;
    dim = eff_dim();
    for (int r = 0; r < dim; r++)
      for (int c = 0; c < dim; c++)
        send_item(OP_LOAD_MAT, g, r, c, random_entry());
  endtask

  task automatic load_vector(input bit all_zero);
    int dim;
    dim = eff_dim();
    for (int r = 0; r < dim; r++)
      send_item(OP_LOAD_VEC, $urandom, r, $urandom, all_zero ? 8'd0 : random_entry());
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: send_item(OP_LOAD_MAT, $urandom, $urandom, $urandom, $urandom);
      1: send_item(OP_LOAD_VEC, $urandom, $urandom, $urandom, $urandom);
      default: send_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
    endcase
  endtask

  // Full matrices for the lowest and highest generator so any dimension can apply them
  task automatic preload_generators();
    fill_generator(4'd0);
    fill_generator(4'd15);
  endtask

  task automatic test_zero_vector();
    send_item(OP_APPLY, 4'd0, 4'd0, 4'd0, 8'd0);
    drain_results();
  endtask

  task automatic test_element_extremes();
    set_config(8'd251, 8'd16);
    send_item(OP_LOAD_VEC, 4'd0, 4'd0, 4'd0, 8'd250);
    send_item(OP_LOAD_VEC, 4'd15, 4'd15, 4'd15, 8'd255);
    send_item(OP_LOAD_VEC, 4'd0, 4'd7, 4'd0, 8'd1);
    send_item(OP_APPLY, 4'd15, 4'd0, 4'd0, 8'd0);
    send_item(OP_LOAD_MAT, 4'd15, 4'd15, 4'd15, 8'd255);
    send_item(OP_LOAD_MAT, 4'd15, 4'd0, 4'd15, 8'd0);
    send_item(OP_APPLY, 4'd15, 4'd15, 4'd15, 8'd255);
    send_item(OP_UNUSED, 4'd15, 4'd15, 4'd15, 8'd255);
    send_item(OP_APPLY, 4'd0, 4'd0, 4'd0, 8'd0);
  endtask

  task automatic test_dim_and_modulus_limits();
    set_config(8'd0, 8'd0);
    send_item(OP_LOAD_VEC, 4'd0, 4'd0, 4'd0, 8'd3);
    send_item(OP_APPLY, 4'd15, 4'd0, 4'd0, 8'd0);
    set_config(8'd1, 8'd31);
    send_item(OP_APPLY, 4'd0, 4'd0, 4'd0, 8'd0);
    set_config(8'd255, 8'd17);
    send_item(OP_APPLY, 4'd15, 4'd0, 4'd0, 8'd0);
    set_config(8'd2, 8'd1);
    send_item(OP_LOAD_VEC, 4'd0, 4'd9, 4'd0, 8'd200);
    send_item(OP_APPLY, 4'd0, 4'd0, 4'd0, 8'd0);
  endtask

  // Hold the receiver off while items keep coming so the input stalls
  task automatic test_backpressure();
    set_config(8'd97, 8'd16);
    load_vector(1'b0);
    long_hold_req = 1'b1;
    send_item(OP_APPLY, 4'd0, 4'd0, 4'd0, 8'd0);
    send_item(OP_APPLY, 4'd15, 4'd0, 4'd0, 8'd0);
    send_item(OP_LOAD_VEC, 4'd0, 4'd3, 4'd0, 8'd5);
    send_item(OP_APPLY, 4'd0, 4'd0, 4'd0, 8'd0);
    drain_results();
  endtask

  task automatic test_paused_words();
    set_config(8'd11, 8'd4);
    fill_generator(4'd5);
    fill_generator(4'd10);
    load_vector(1'b0);
    repeat (3) begin
      send_item(OP_APPLY, ($urandom_range(0, 1) != 0) ? 4'd5 : 4'd10, 4'd0, 4'd0, 8'd0);
      drain_results();
    end
  endtask

  task automatic run_random_phase(input logic [CFG_DATA_BITS-1:0] modulus,
                                  input logic [CFG_DATA_BITS-1:0] dim, input int budget);
    int start;
    set_config(modulus, dim);
    start = items_sent;
    while (items_sent - start < budget) begin
      case ($urandom_range(0, 9))
        0, 1: load_vector($urandom_range(0, 5) == 0);
        2: begin
          if (eff_dim() <= 6) fill_generator($urandom);
          else send_noise();
        end
        3: send_noise();
        default: begin
          repeat ($urandom_range(1, 4)) send_item(OP_APPLY, pick_loaded_gen(), $urandom,
                                                  $urandom, $urandom);
        end
      endcase
    end
  endtask

  task automatic test_random_words();
    int mods [8] = '{7, 251, 2, 13, 0, 255, 101, 3};
    int dims [8] = '{3, 4, 2, 16, 5, 1, 6, 31};
    for (int p = 0; p < 8; p++)
      run_random_phase(mods[p], dims[p], 28);
  endtask

  // Receiver: segments of always-ready, random and slow acceptance
  initial begin
    int mode;
    int seg_len;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        mode    = $urandom_range(0, 2);
        seg_len = $urandom_range(4, 40);
        repeat (seg_len) begin
          case (mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 2) != 0);
            default: out_ch.ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_elements.size() == 0) begin
        report_mismatch($sformatf("unexpected element index %0d value %0d",
                                  out_ch.element_index, out_ch.element_value));
      end else begin
        head_elem = pending_elements.pop_front();
        if (out_ch.element_index !== head_elem.idx)
          report_mismatch($sformatf("element_index %0d, want %0d",
                                    out_ch.element_index, head_elem.idx));
        if (out_ch.element_value !== head_elem.value)
          report_mismatch($sformatf("element_value %0d at index %0d, want %0d",
                                    out_ch.element_value, head_elem.idx, head_elem.value));
        if (out_ch.last !== head_elem.last)
          report_mismatch($sformatf("last %b at index %0d, want %b",
                                    out_ch.last, head_elem.idx, head_elem.last));
      end
    end
  end

  // Count cycles without any accepted item on any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_modp_vector_matrix_word_action_core NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = '0;
    in_ch.generator = '0;
    in_ch.row       = '0;
    in_ch.column    = '0;
    in_ch.entry     = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_MODULUS;
    cfg_ch.data     = '0;
    error_count     = 0;
    print_count     = 0;
    items_sent      = 0;
    burst_left      = 0;
    quiet_cycles    = 0;
    long_hold_req   = 1'b0;
    reset_predictor();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    preload_generators();
    test_zero_vector();
    test_element_extremes();
    test_dim_and_modulus_limits();
    test_backpressure();
    test_paused_words();
    test_random_words();

    drain_results();
    if (error_count == 0) begin
      $display("tb_modp_vector_matrix_word_action_core OK");
    end else begin
      $display("tb_modp_vector_matrix_word_action_core NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/mvw_pkg.sv
design/mvw_in_if.sv
design/mvw_out_if.sv
design/mvw_cfg_if.sv
design/mvw_cell.sv
design/mvw_ctrl.sv
design/modp_vector_matrix_word_action_core.sv
test/tb_modp_vector_matrix_word_action_core.sv
